// ----- design/keyed_connection_table_assert.svh -----
// ----------------------------------------------------------------------------
// keyed_connection_table assertion macros
// Clocked, reset-gated property helpers shared by the table's RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_CONNECTION_TABLE_ASSERT_SVH
`define KEYED_CONNECTION_TABLE_ASSERT_SVH

// same-cycle implication
`define KCT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_connection_table: check failed");

// next-cycle implication
`define KCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_connection_table: check failed");

`endif

// ----- design/kct_pkg.sv -----
// ----------------------------------------------------------------------------
// kct_pkg
// Field widths, command and status codes, and the stored entry type of the
// keyed connection table.
// ----------------------------------------------------------------------------
package kct_pkg;

	localparam int KEY_W     = 64;
	localparam int CONN_W    = 16;
	localparam int STATUS_W  = 3;
	localparam int CNT_OUT_W = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_LIST   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CONN_W-1:0] conn;
	} kct_entry_t;

endpackage

// ----- design/keyed_connection_table.sv -----
// ----------------------------------------------------------------------------
// keyed_connection_table
// Newest-first table of identifier keys mapped to connection numbers.
// ----------------------------------------------------------------------------
// Requests (command, key, conn_value) enter on req_valid/req_ready; results
// (status, found_conn, listed_key, entry_count, last) leave on
// res_valid/res_ready. Entries sit in one single-port-write, registered-read
// memory, slot 0 newest; a fill count marks the valid slots.
// Insert, remove and lookup first walk the held entries, one read per cycle.
// Insert then shifts every entry up one slot and writes slot 0; remove
// shifts the entries behind the hit down one slot. Each result then
// waits in a result register until the output register is free.
// List reads one entry at a time and emits one result per key, the
// final one marked last; an empty table gives one result with status empty.
// One request is worked at a time; a new request is taken as soon as its
// predecessor's final result sits in the output register.
// A stalled receiver holds the output register and the table waits on it.
// Reset empties the table at once; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "keyed_connection_table_assert.svh"

module keyed_connection_table import kct_pkg::*; #(
	parameter int ID_BYTES = 8,
	parameter int ENTRIES  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           command,
	input  logic [KEY_W-1:0]     key,
	input  logic [CONN_W-1:0]    conn_value,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [CONN_W-1:0]    found_conn,
	output logic [KEY_W-1:0]     listed_key,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic                 last
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * ID_BYTES);
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_SHUP = 3'd2;
	localparam logic [2:0] S_SHDN = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;
	localparam logic [2:0] S_LRD  = 3'd5;
	localparam logic [2:0] S_LOUT = 3'd6;

	// table memory
	kct_entry_t mem [ENTRIES];
	kct_entry_t rd_q;
	logic       rd_en;
	logic [AW-1:0] rd_addr;
	logic       wr_en;
	logic [AW-1:0] wr_addr;
	kct_entry_t wr_data;

	// control
	logic [2:0]        state_q, state_n;
	logic [CW-1:0]     count_q, count_n;
	logic [CW-1:0]     ptr_q, ptr_n;
	logic              pend_s1, pend_n;
	logic [AW-1:0]     idx_s1, idx_n;
	logic [1:0]        cmd_q, cmd_n;
	logic [KEY_W-1:0]  key_q, key_n;
	logic [CONN_W-1:0] conn_q, conn_n;
	logic [STATUS_W-1:0] rsp_status_q, rsp_status_n;
	logic [CONN_W-1:0] rsp_conn_q, rsp_conn_n;

	// output register
	logic                res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [CONN_W-1:0]   found_conn_q;
	logic [KEY_W-1:0]    listed_key_q;
	logic [CNT_OUT_W-1:0] entry_count_q;
	logic                last_q;

	logic                ld;
	logic [STATUS_W-1:0] ld_status;
	logic [CONN_W-1:0]   ld_conn;
	logic [KEY_W-1:0]    ld_key;
	logic                ld_last;
	logic                out_free;
	logic                hit_c;
	logic [CW-1:0]       ptr_m1;
	logic [CW+CNT_OUT_W-1:0] count_wide;

	assign out_free   = !res_valid_q || res_ready;
	assign hit_c      = pend_s1 && (rd_q.key == key_q);
	assign ptr_m1     = ptr_q - CW'(1);
	assign count_wide = {{CNT_OUT_W{1'b0}}, count_q};
	assign req_ready  = (state_q == S_IDLE);

	always_comb begin
		state_n      = state_q;
		count_n      = count_q;
		ptr_n        = ptr_q;
		pend_n       = pend_s1;
		idx_n        = idx_s1;
		cmd_n        = cmd_q;
		key_n        = key_q;
		conn_n       = conn_q;
		rsp_status_n = rsp_status_q;
		rsp_conn_n   = rsp_conn_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = rd_q;
		ld           = 1'b0;
		ld_status    = ST_OK;
		ld_conn      = '0;
		ld_key       = '0;
		ld_last      = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_n  = command;
					key_n  = key & KEY_MASK;
					conn_n = conn_value;
					ptr_n  = '0;
					pend_n = 1'b0;
					if (command == CMD_LIST) begin
						if (count_q == '0) begin
							rsp_status_n = ST_EMPTY;
							rsp_conn_n   = '0;
							state_n      = S_RES;
						end else begin
							state_n = S_LRD;
						end
					end else begin
						state_n = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (hit_c) begin
					pend_n     = 1'b0;
					rsp_conn_n = '0;
					case (cmd_q)
						CMD_INSERT: begin
							rsp_status_n = ST_DUP;
							state_n      = S_RES;
						end
						CMD_REMOVE: begin
							ptr_n   = CW'(idx_s1) + CW'(1);
							state_n = S_SHDN;
						end
						default: begin
							rsp_status_n = ST_OK;
							rsp_conn_n   = rd_q.conn;
							state_n      = S_RES;
						end
					endcase
				end else if (!pend_s1 && ptr_q == count_q) begin
					rsp_conn_n = '0;
					if (cmd_q == CMD_INSERT) begin
						if (count_q == FULL_CNT) begin
							rsp_status_n = ST_FULL;
							state_n      = S_RES;
						end else begin
							ptr_n   = count_q;
							state_n = S_SHUP;
						end
					end else begin
						rsp_status_n = ST_NOTFOUND;
						state_n      = S_RES;
					end
				end else if (ptr_q != count_q) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q[AW-1:0];
					ptr_n   = ptr_q + CW'(1);
					pend_n  = 1'b1;
					idx_n   = ptr_q[AW-1:0];
				end else begin
					pend_n = 1'b0;
				end
			end
			S_SHUP: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 + AW'(1);
					wr_data = rd_q;
				end
				if (ptr_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ptr_m1[AW-1:0];
					ptr_n   = ptr_m1;
					pend_n  = 1'b1;
					idx_n   = ptr_m1[AW-1:0];
				end else begin
					pend_n = 1'b0;
					if (!pend_s1) begin
						wr_en        = 1'b1;
						wr_addr      = '0;
						wr_data.key  = key_q;
						wr_data.conn = conn_q;
						count_n      = count_q + CW'(1);
						rsp_status_n = ST_OK;
						rsp_conn_n   = '0;
						state_n      = S_RES;
					end
				end
			end
			S_SHDN: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 - AW'(1);
					wr_data = rd_q;
				end
				if (ptr_q != count_q) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q[AW-1:0];
					ptr_n   = ptr_q + CW'(1);
					pend_n  = 1'b1;
					idx_n   = ptr_q[AW-1:0];
				end else begin
					pend_n = 1'b0;
					if (!pend_s1) begin
						count_n      = count_q - CW'(1);
						rsp_status_n = ST_OK;
						rsp_conn_n   = '0;
						state_n      = S_RES;
					end
				end
			end
			S_RES: begin
				if (out_free) begin
					ld        = 1'b1;
					ld_status = rsp_status_q;
					ld_conn   = rsp_conn_q;
					state_n   = S_IDLE;
				end
			end
			S_LRD: begin
				rd_en   = 1'b1;
				rd_addr = ptr_q[AW-1:0];
				ptr_n   = ptr_q + CW'(1);
				state_n = S_LOUT;
			end
			S_LOUT: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_key  = rd_q.key;
					ld_last = (ptr_q == count_q);
					state_n = (ptr_q == count_q) ? S_IDLE : S_LRD;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// memory ports, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			pend_s1 <= pend_n;
			if (ld) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q        <= ptr_n;
		idx_s1       <= idx_n;
		cmd_q        <= cmd_n;
		key_q        <= key_n;
		conn_q       <= conn_n;
		rsp_status_q <= rsp_status_n;
		rsp_conn_q   <= rsp_conn_n;
		if (ld) begin
			status_q      <= ld_status;
			found_conn_q  <= ld_conn;
			listed_key_q  <= ld_key;
			entry_count_q <= count_wide[CNT_OUT_W-1:0];
			last_q        <= ld_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign found_conn  = found_conn_q;
	assign listed_key  = listed_key_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

	`KCT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= FULL_CNT)
	`KCT_ASSERT_SAME(a_write_in_shift, wr_en, state_q == S_SHUP || state_q == S_SHDN)
	`KCT_ASSERT_SAME(a_search_in_range, rd_en && state_q == S_SRCH, ptr_q < count_q)
	`KCT_ASSERT_NEXT(a_insert_grows, state_q == S_SHUP && ptr_q == '0 && !pend_s1,
		count_q == $past(count_q) + CW'(1))
	`KCT_ASSERT_NEXT(a_load_shows, ld, res_valid_q)

endmodule

// ----- tb/kct_result_checker.sv -----
// ----------------------------------------------------------------------------
// kct_result_checker
// Watches both channels of the keyed connection table, keeps its own copy
// of the newest-first table, works out the results of every accepted request
// and compares each accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module kct_result_checker import kct_pkg::*; #(
	parameter int ID_BYTES = 8,
	parameter int ENTRIES  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  logic [1:0]           command,
	input  logic [KEY_W-1:0]     key,
	input  logic [CONN_W-1:0]    conn_value,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  logic [STATUS_W-1:0]  status,
	input  logic [CONN_W-1:0]    found_conn,
	input  logic [KEY_W-1:0]     listed_key,
	input  logic [CNT_OUT_W-1:0] entry_count,
	input  logic                 last,
	output int                   pending,
	output int                   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KEY_W-1:0] KEY_MASK =
		(ID_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * ID_BYTES)) - 64'd1);

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [CONN_W-1:0]    conn;
		logic [KEY_W-1:0]     lkey;
		logic [CNT_OUT_W-1:0] count;
		logic                 last;
	} table_result_t;

	logic [KEY_W-1:0]  held_key  [ENTRIES];
	logic [CONN_W-1:0] held_conn [ENTRIES];
	int                held_n = 0;
	table_result_t     awaited_results[$];
	int                errors = 0;

	function automatic int find_slot(input logic [KEY_W-1:0] k);
		for (int i = 0; i < held_n; i++)
			if (held_key[i] == k)
				return i;
		return -1;
	endfunction

	task automatic push_result(input logic [STATUS_W-1:0] st, input logic [CONN_W-1:0] c,
			input logic [KEY_W-1:0] lk, input logic lst);
		table_result_t r;
		r.status = st;
		r.conn   = c;
		r.lkey   = lk;
		r.count  = CNT_OUT_W'(held_n);
		r.last   = lst;
		awaited_results.push_back(r);
	endtask

	task automatic apply_request(input logic [1:0] cmd, input logic [KEY_W-1:0] raw_key,
			input logic [CONN_W-1:0] c);
		logic [KEY_W-1:0] k;
		int pos;
		k = raw_key & KEY_MASK;
		pos = find_slot(k);
		case (cmd)
			CMD_INSERT: begin
				if (pos >= 0) begin
					push_result(ST_DUP, '0, '0, 1'b1);
				end else if (held_n >= ENTRIES) begin
					push_result(ST_FULL, '0, '0, 1'b1);
				end else begin
					for (int i = held_n; i > 0; i--) begin
						held_key[i]  = held_key[i-1];
						held_conn[i] = held_conn[i-1];
					end
					held_key[0]  = k;
					held_conn[0] = c;
					held_n++;
					push_result(ST_OK, '0, '0, 1'b1);
				end
			end
			CMD_REMOVE: begin
				if (pos < 0) begin
					push_result(ST_NOTFOUND, '0, '0, 1'b1);
				end else begin
					for (int i = pos; i + 1 < held_n; i++) begin
						held_key[i]  = held_key[i+1];
						held_conn[i] = held_conn[i+1];
					end
					held_n--;
					push_result(ST_OK, '0, '0, 1'b1);
				end
			end
			CMD_LOOKUP: begin
				if (pos < 0)
					push_result(ST_NOTFOUND, '0, '0, 1'b1);
				else
					push_result(ST_OK, held_conn[pos], '0, 1'b1);
			end
			default: begin
				if (held_n == 0) begin
					push_result(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (int i = 0; i < held_n; i++)
						push_result(ST_OK, '0, held_key[i], i + 1 == held_n);
				end
			end
		endcase
	endtask

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		table_result_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: result with none due, status %h key %h", $time, status, listed_key);
			errors++;
		end else begin
			want = awaited_results.pop_front();
			report_field("status", 64'(want.status), 64'(status));
			report_field("found_conn", 64'(want.conn), 64'(found_conn));
			report_field("listed_key", want.lkey, listed_key);
			report_field("entry_count", 64'(want.count), 64'(entry_count));
			report_field("last", 64'(want.last), 64'(last));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			held_n = 0;
			awaited_results.delete();
		end else begin
			if (req_valid && req_ready)
				apply_request(command, key, conn_value);
			if (res_valid && res_ready)
				check_result();
		end
		pending <= awaited_results.size();
		fail_count <= errors;
	end

endmodule

// ----- tb/tb_keyed_connection_table.sv -----
// ----------------------------------------------------------------------------
// tb_keyed_connection_table
// Drives directed and random insert, remove, lookup and list requests into
// the keyed connection table with random gaps on both channels and one long
// receiver hold-off, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_keyed_connection_table import kct_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_BYTES   = 8;
	localparam int ENTRIES    = 16;
	localparam int KEY_POOL   = 24;
	localparam int SEGMENTS   = 11;
	localparam int SEG_ITEMS  = 20;
	localparam int HOLD_OFF   = 200;
	localparam int HOLD_AT    = 50;
	localparam int DRAIN_WAIT = 100;
	localparam int IDLE_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic [1:0]           command = CMD_INSERT;
	logic [KEY_W-1:0]     key = '0;
	logic [CONN_W-1:0]    conn_value = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [CONN_W-1:0]    found_conn;
	logic [KEY_W-1:0]     listed_key;
	logic [CNT_OUT_W-1:0] entry_count;
	logic                 last;
	int                   pending;
	int                   fail_count;

	int               sent = 0;
	int               taken = 0;
	int               idle_cycles = 0;
	int               rx_gap;
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	always #5 clk = ~clk;

	keyed_connection_table #(
		.ID_BYTES(ID_BYTES),
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.command(command),
		.key(key),
		.conn_value(conn_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status(status),
		.found_conn(found_conn),
		.listed_key(listed_key),
		.entry_count(entry_count),
		.last(last)
	);

	kct_result_checker #(
		.ID_BYTES(ID_BYTES),
		.ENTRIES(ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.command(command),
		.key(key),
		.conn_value(conn_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status(status),
		.found_conn(found_conn),
		.listed_key(listed_key),
		.entry_count(entry_count),
		.last(last),
		.pending(pending),
		.fail_count(fail_count)
	);

	// every fourth stretch of 40 runs back to back
	function automatic int draw_gap(input int n);
		if ((n / 40) % 4 == 3)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
			input logic [CONN_W-1:0] c);
		int gap;
		gap = draw_gap(sent);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		command    <= cmd;
		key        <= k;
		conn_value <= c;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	function automatic logic [1:0] pick_command(input int phase);
		int roll;
		roll = $urandom_range(0, 99);
		case (phase)
			0: return roll < 80 ? CMD_INSERT : roll < 85 ? CMD_REMOVE :
				roll < 95 ? CMD_LOOKUP : CMD_LIST;
			1: return roll < 35 ? CMD_INSERT : roll < 55 ? CMD_REMOVE :
				roll < 85 ? CMD_LOOKUP : CMD_LIST;
			default: return roll < 15 ? CMD_INSERT : roll < 75 ? CMD_REMOVE :
				roll < 90 ? CMD_LOOKUP : CMD_LIST;
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_request(CMD_LIST,   '0, '0);
		send_request(CMD_LOOKUP, '0, '0);
		send_request(CMD_REMOVE, '1, '0);
		// extremes of key and connection
		send_request(CMD_INSERT, '0, 16'hffff);
		send_request(CMD_INSERT, '1, 16'h0000);
		send_request(CMD_INSERT, '0, 16'h1234);
		send_request(CMD_INSERT, 64'h8000_0000_0000_0001, 16'h8001);
		send_request(CMD_LOOKUP, '0, '0);
		send_request(CMD_LOOKUP, '1, 16'hffff);
		send_request(CMD_LOOKUP, 64'h1, '0);
		send_request(CMD_LIST,   '0, '0);
		// remove from the middle keeps order
		send_request(CMD_REMOVE, '1, '0);
		send_request(CMD_LIST,   '0, '0);
		send_request(CMD_REMOVE, '0, '0);
		send_request(CMD_REMOVE, 64'h8000_0000_0000_0001, '0);
		send_request(CMD_LIST,   '0, '0);

		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, $urandom};

		// fill, mixed and drain phases over a small key pool
		for (int s = 0; s < SEGMENTS; s++) begin
			for (int j = 0; j < SEG_ITEMS; j++) begin
				send_request(pick_command(s % 3),
					($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
						key_pool[$urandom_range(0, KEY_POOL - 1)],
					16'($urandom));
			end
		end
		req_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("tb_keyed_connection_table: clean");
		else
			$display("tb_keyed_connection_table: errors");
		$finish;
	end

	// receiver, with one long hold-off while requests keep coming
	initial begin
		wait (arst_n);
		forever begin
			rx_gap = (taken == HOLD_AT) ? HOLD_OFF : draw_gap(taken);
			if (rx_gap > 0) begin
				res_ready <= 1'b0;
				repeat (rx_gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			taken++;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_keyed_connection_table: errors");
			$finish;
		end
	end

endmodule
